// ===== src/tpad_pkg.sv =====
// Shared types, register map and firing-delay table for the triac phase-angle dimmer.
`default_nettype none

package tpad_pkg;

    localparam int DELAY_W     = 14;
    localparam int ROM_DEPTH   = 256;
    localparam int ROM_IDX_W   = 8;
    localparam int OUT_PHASE_W = 16;
    localparam int BRIGHT_W    = 8;
    localparam int LOCKOUT_W   = 16;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 24;
    localparam int APB_ADDR_W  = 3;

    localparam logic [DELAY_W-1:0]    DELAY_NEVER   = 14'd10000;
    localparam logic [BRIGHT_W-1:0]   BRIGHT_RESET  = 8'd0;
    localparam logic [LOCKOUT_W-1:0]  LOCKOUT_RESET = 16'd9000;

    localparam logic [APB_ADDR_W-1:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [APB_ADDR_W-1:0] REG_LOCKOUT    = 3'd4;

    typedef struct packed {
        logic                   edge_accepted;
        logic [OUT_PHASE_W-1:0] phase;
        logic                   triac_drive;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    localparam logic [DELAY_W-1:0] DELAY_ROM [ROM_DEPTH] = '{
        14'd0,    14'd398,  14'd564,  14'd691,  14'd799,  14'd894,  14'd980,  14'd1059,
        14'd1133, 14'd1203, 14'd1269, 14'd1331, 14'd1392, 14'd1449, 14'd1505, 14'd1559,
        14'd1611, 14'd1662, 14'd1711, 14'd1760, 14'd1807, 14'd1852, 14'd1897, 14'd1941,
        14'd1985, 14'd2027, 14'd2069, 14'd2109, 14'd2150, 14'd2189, 14'd2228, 14'd2267,
        14'd2305, 14'd2342, 14'd2379, 14'd2416, 14'd2452, 14'd2487, 14'd2523, 14'd2557,
        14'd2592, 14'd2626, 14'd2660, 14'd2693, 14'd2727, 14'd2759, 14'd2792, 14'd2824,
        14'd2856, 14'd2888, 14'd2920, 14'd2951, 14'd2982, 14'd3013, 14'd3044, 14'd3074,
        14'd3104, 14'd3135, 14'd3164, 14'd3194, 14'd3224, 14'd3253, 14'd3282, 14'd3311,
        14'd3340, 14'd3369, 14'd3397, 14'd3426, 14'd3454, 14'd3482, 14'd3510, 14'd3538,
        14'd3566, 14'd3594, 14'd3621, 14'd3649, 14'd3676, 14'd3703, 14'd3730, 14'd3757,
        14'd3784, 14'd3811, 14'd3838, 14'd3865, 14'd3891, 14'd3918, 14'd3944, 14'd3971,
        14'd3997, 14'd4023, 14'd4049, 14'd4075, 14'd4101, 14'd4127, 14'd4153, 14'd4179,
        14'd4205, 14'd4231, 14'd4256, 14'd4282, 14'd4308, 14'd4333, 14'd4359, 14'd4384,
        14'd4409, 14'd4435, 14'd4460, 14'd4485, 14'd4511, 14'd4536, 14'd4561, 14'd4586,
        14'd4612, 14'd4637, 14'd4662, 14'd4687, 14'd4712, 14'd4737, 14'd4762, 14'd4787,
        14'd4812, 14'd4837, 14'd4862, 14'd4887, 14'd4912, 14'd4937, 14'd4962, 14'd4987,
        14'd5012, 14'd5037, 14'd5062, 14'd5087, 14'd5112, 14'd5137, 14'd5162, 14'd5187,
        14'd5212, 14'd5237, 14'd5262, 14'd5287, 14'd5312, 14'd5337, 14'd5362, 14'd5387,
        14'd5413, 14'd5438, 14'd5463, 14'd5488, 14'd5514, 14'd5539, 14'd5564, 14'd5590,
        14'd5615, 14'd5640, 14'd5666, 14'd5691, 14'd5717, 14'd5743, 14'd5768, 14'd5794,
        14'd5820, 14'd5846, 14'd5872, 14'd5898, 14'd5924, 14'd5950, 14'd5976, 14'd6002,
        14'd6028, 14'd6055, 14'd6081, 14'd6108, 14'd6134, 14'd6161, 14'd6188, 14'd6215,
        14'd6242, 14'd6269, 14'd6296, 14'd6323, 14'd6350, 14'd6378, 14'd6405, 14'd6433,
        14'd6461, 14'd6489, 14'd6517, 14'd6545, 14'd6573, 14'd6602, 14'd6630, 14'd6659,
        14'd6688, 14'd6717, 14'd6746, 14'd6775, 14'd6805, 14'd6835, 14'd6864, 14'd6895,
        14'd6925, 14'd6955, 14'd6986, 14'd7017, 14'd7048, 14'd7079, 14'd7111, 14'd7143,
        14'd7175, 14'd7207, 14'd7240, 14'd7272, 14'd7306, 14'd7339, 14'd7373, 14'd7407,
        14'd7442, 14'd7476, 14'd7512, 14'd7547, 14'd7583, 14'd7620, 14'd7657, 14'd7694,
        14'd7732, 14'd7771, 14'd7810, 14'd7849, 14'd7890, 14'd7930, 14'd7972, 14'd8014,
        14'd8058, 14'd8102, 14'd8147, 14'd8192, 14'd8239, 14'd8288, 14'd8337, 14'd8388,
        14'd8440, 14'd8494, 14'd8550, 14'd8607, 14'd8668, 14'd8730, 14'd8796, 14'd8866,
        14'd8940, 14'd9019, 14'd9105, 14'd9200, 14'd9308, 14'd9435, 14'd9601, 14'd10000
    };

endpackage

`default_nettype wire

// ===== src/triac_phase_angle_dimmer.sv =====
// Triac phase-angle dimmer: zero-cross edge lockout, phase counter and firing control.
`default_nettype none

// One input word is one microsecond tick with the zero-cross pin level; each tick yields
// one output word with the gate level, the 16-bit phase count and an edge-accepted flag.
// A word is taken every clock cycle while the skid stage is empty: the whole update is one
// pass of logic from the state registers into an output register, and a one-word skid
// stage takes one word while the output side stalls. The firing delay comes from a
// 256-entry table indexed by LEVEL_COUNT-1 minus brightness. The user must write
// configuration over APB only while the stream is idle; the block does not enforce it.
module triac_phase_angle_dimmer
    import tpad_pkg::*;
#(
    parameter int LEVEL_COUNT = 256,
    parameter int PHASE_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,   // [0] zero_cross

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,   // [0] triac_drive, [16:1] phase,
                                                        // [17] edge_accepted

    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int TOP_W = ($clog2(LEVEL_COUNT) > BRIGHT_W) ? $clog2(LEVEL_COUNT) : BRIGHT_W;
    localparam logic [TOP_W-1:0] LEVEL_TOP = TOP_W'(LEVEL_COUNT - 1);
    localparam logic [TOP_W-1:0] ROM_TOP   = TOP_W'(ROM_DEPTH - 1);
    localparam int CMP_W = (PHASE_WIDTH > LOCKOUT_W) ? PHASE_WIDTH : LOCKOUT_W;

    logic [BRIGHT_W-1:0]    r_brightness;
    logic [LOCKOUT_W-1:0]   r_lockout;

    logic                   r_prev_pin;
    logic [PHASE_WIDTH-1:0] r_phase;
    logic                   r_edge_seen;
    logic                   r_in_lockout;
    logic                   r_armed;
    logic                   r_gate;

    logic [PHASE_WIDTH-1:0] n_phase;
    logic                   n_edge_seen;
    logic                   n_in_lockout;
    logic                   n_armed;
    logic                   n_gate;

    t_result                r_out;
    logic                   r_out_valid;
    t_result                r_skid;
    logic                   r_skid_valid;
    t_result                n_result;

    logic                   in_acc;
    logic                   out_free;
    logic                   apb_wr;
    logic                   pin;
    logic                   rising;
    logic                   lock_hold;
    logic                   take_edge;
    logic [PHASE_WIDTH-1:0] phase_inc;
    logic [TOP_W-1:0]       bright_ext;
    logic [TOP_W-1:0]       idx_diff;
    logic [ROM_IDX_W-1:0]   rom_idx;
    logic [DELAY_W-1:0]     delay;

    assign pready = 1'b1;
    assign apb_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= BRIGHT_RESET;
            r_lockout    <= LOCKOUT_RESET;
        end else if (apb_wr) begin
            unique case (paddr)
                REG_BRIGHTNESS: r_brightness <= pwdata[BRIGHT_W-1:0];
                REG_LOCKOUT:    r_lockout    <= pwdata[LOCKOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            REG_BRIGHTNESS: prdata = {{(32-BRIGHT_W){1'b0}}, r_brightness};
            REG_LOCKOUT:    prdata = {{(32-LOCKOUT_W){1'b0}}, r_lockout};
            default:        prdata = '0;
        endcase
    end

    assign bright_ext = TOP_W'(r_brightness);
    assign idx_diff   = (bright_ext > LEVEL_TOP) ? '0 : (LEVEL_TOP - bright_ext);
    assign rom_idx    = (idx_diff > ROM_TOP) ? ROM_IDX_W'(ROM_DEPTH - 1)
                                             : idx_diff[ROM_IDX_W-1:0];
    assign delay      = DELAY_ROM[rom_idx];

    assign s_axis_tready = ~r_skid_valid;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign pin           = s_axis_tdata[0];
    assign rising        = pin & ~r_prev_pin;
    assign phase_inc     = r_phase + PHASE_WIDTH'(1);

    always_comb begin
        lock_hold = r_in_lockout
                    & ~((CMP_W'(phase_inc) >= CMP_W'(r_lockout)) | (phase_inc == '0));
        take_edge = rising & (~r_edge_seen | ~lock_hold);

        n_phase      = phase_inc;
        n_edge_seen  = r_edge_seen;
        n_in_lockout = lock_hold;
        n_armed      = r_armed;
        n_gate       = r_gate;

        if (take_edge) begin
            n_phase      = '0;
            n_edge_seen  = 1'b1;
            n_in_lockout = (r_lockout != '0);
            if (delay == '0) begin
                n_gate  = 1'b1;
                n_armed = 1'b0;
            end else begin
                n_gate  = 1'b0;
                n_armed = (delay < DELAY_NEVER);
            end
        end else if (r_armed && (phase_inc == PHASE_WIDTH'(delay))) begin
            n_gate  = 1'b1;
            n_armed = 1'b0;
        end

        n_result.triac_drive   = n_gate;
        n_result.phase         = OUT_PHASE_W'(n_phase);
        n_result.edge_accepted = take_edge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pin   <= 1'b0;
            r_phase      <= '0;
            r_edge_seen  <= 1'b0;
            r_in_lockout <= 1'b0;
            r_armed      <= 1'b0;
            r_gate       <= 1'b0;
        end else if (in_acc) begin
            r_prev_pin   <= pin;
            r_phase      <= n_phase;
            r_edge_seen  <= n_edge_seen;
            r_in_lockout <= n_in_lockout;
            r_armed      <= n_armed;
            r_gate       <= n_gate;
        end
    end

    assign out_free = ~r_out_valid | m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_result;
            end
        end else if (in_acc) begin
            r_skid <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-RESULT_W){1'b0}}, r_out};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without output word");

    a_armed_gate_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> !r_gate)
        else $error("firing armed while gate already on");

    a_edge_zero_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && take_edge) |=> (r_phase == '0) && r_edge_seen)
        else $error("accepted edge did not restart phase");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_phase) && $stable(r_gate))
        else $error("state moved without an accepted word");

endmodule

`default_nettype wire
